[hdl/smf_pkg.sv]
// ----------------------------------------------------------------------------
// smf_pkg
// Shared constants and types of the sliding-window median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int WINDOW_MAX = 32;
    localparam int WIN_MIN    = 3;
    localparam int WIN_RESET  = 5;
    localparam int SAMPLE_W   = 16;
    localparam int RESULT_W   = SAMPLE_W + 1;
    localparam int CFG_W      = 6;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int EXT_W      = CFG_W + CNT_W;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    // register index taken from paddr word bit
    localparam logic REG_WIN_LEN = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [RESULT_W-1:0] t_result;

    typedef struct packed {
        t_sample          value;
        logic [IDX_W-1:0] age;
        logic             gt;
        logic             del;
    } t_cell_out;

    typedef struct packed {
        t_sample          x;
        logic             ins;
        logic             full;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] size_m1;
    } t_chain_ctrl;

endpackage

[hdl/sliding_window_median.sv]
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median over the last window-length valid samples, given as twice
// the median; an invalid sample repeats the previous result.
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+------------------------------
//  input    | i_in_valid / o_in_ready           | i_sample, i_sample_valid
//  output   | o_out_valid / i_out_ready         | o_median_twice
//  config   | psel, penable, pwrite, pready     | paddr, pwdata, prdata
//
//  One transfer per cycle while the output is not stalled: the cell row sorts
//  on the accepting edge, the middle taps are added into the output register
//  when the pending item moves on to the output.
//  Synchronous active-low reset; the window length resets to 5, store empty.
//  A stalled output holds one result and one sorted item; input then waits.
// ----------------------------------------------------------------------------
module sliding_window_median import smf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_sample_valid,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [RESULT_W-1:0] o_median_twice,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    logic [CFG_W-1:0] r_win_len;
    logic [CNT_W-1:0] r_count;
    logic             r_pend;
    logic             r_pend_ok;
    logic             r_out_valid;
    t_result          r_out;
    t_result          r_last;

    logic [CNT_W-1:0] size;
    logic [EXT_W-1:0] ws_ext;
    logic             in_xfer;
    logic             move;
    logic             cfg_wr;
    t_chain_ctrl      ctrl;
    t_sample          tap_lo;
    t_sample          tap_hi;
    t_result          med_sum;
    t_result          n_result;

    always_comb begin
        ws_ext = EXT_W'(r_win_len);
        if (ws_ext < EXT_W'(WIN_MIN)) begin
            size = CNT_W'(WIN_MIN);
        end else if (ws_ext > EXT_W'(WINDOW_MAX)) begin
            size = CNT_W'(WINDOW_MAX);
        end else begin
            size = CNT_W'(r_win_len);
        end
    end

    assign move       = r_pend && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_pend || move;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign cfg_wr     = psel && penable && pwrite && pready;

    assign ctrl.x       = i_sample;
    assign ctrl.ins     = in_xfer && i_sample_valid;
    assign ctrl.full    = (r_count == size);
    assign ctrl.count   = r_count;
    assign ctrl.size_m1 = IDX_W'(size - 1'b1);

    smf_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_lo    (tap_lo),
        .o_hi    (tap_hi)
    );

    assign med_sum  = RESULT_W'(tap_lo) + RESULT_W'(tap_hi);
    assign n_result = r_pend_ok ? med_sum : r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= CFG_W'(WIN_RESET);
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_pend_ok   <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= '0;
        end else begin
            if (cfg_wr && paddr[2] == REG_WIN_LEN) begin
                r_win_len <= pwdata[CFG_W-1:0];
                r_count   <= '0;
                r_last    <= '0;
            end else begin
                if (ctrl.ins && !ctrl.full) begin
                    r_count <= r_count + 1'b1;
                end
                if (move) begin
                    r_last <= n_result;
                end
            end
            if (in_xfer) begin
                r_pend    <= 1'b1;
                r_pend_ok <= i_sample_valid;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_median_twice = r_out;
    assign prdata         = APB_DW'(r_win_len);
    assign pready         = 1'b1;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= size)
        else $error("fill count beyond window");

    a_insert_fills : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.ins && !cfg_wr |=> r_count != '0)
        else $error("store empty after a valid sample");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_pend && r_out_valid && !i_out_ready)
        else $error("input held off without a stalled result");

endmodule

[hdl/smf_cell.sv]
// ----------------------------------------------------------------------------
// smf_cell
// One place of the sorted chain: holds a sample and its age, and takes its
// next contents from itself, a neighbour or the incoming sample.
// ----------------------------------------------------------------------------
module smf_cell import smf_pkg::*; (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_index,
    input  t_chain_ctrl      i_ctrl,
    input  logic [IDX_W-1:0] i_del_idx,
    input  t_cell_out        i_left,
    input  t_cell_out        i_right,
    output t_cell_out        o_cell
);

    t_sample          r_value;
    logic [IDX_W-1:0] r_age;
    t_sample          n_value;
    logic [IDX_W-1:0] n_age;

    logic             occ;
    logic             gt;
    logic             dl_me;
    logic             dl_left;
    t_sample          w_me_value;
    logic [IDX_W-1:0] w_me_age;
    logic             w_me_gt;
    t_sample          w_left_value;
    logic [IDX_W-1:0] w_left_age;
    logic             w_left_gt;

    always_comb begin
        occ     = CNT_W'(i_index) < i_ctrl.count;
        gt      = !occ || ($signed(r_value) > $signed(i_ctrl.x));
        dl_me   = i_ctrl.full && (i_index >= i_del_idx);
        dl_left = i_ctrl.full && (i_index > i_del_idx);

        // view after the oldest sample is dropped
        w_me_value   = dl_me ? i_right.value : r_value;
        w_me_age     = dl_me ? i_right.age   : r_age;
        w_me_gt      = dl_me ? i_right.gt    : gt;
        w_left_value = dl_left ? r_value : i_left.value;
        w_left_age   = dl_left ? r_age   : i_left.age;
        w_left_gt    = dl_left ? gt      : i_left.gt;

        if (!w_me_gt) begin
            n_value = w_me_value;
            n_age   = w_me_age + 1'b1;
        end else if (w_left_gt) begin
            n_value = w_left_value;
            n_age   = w_left_age + 1'b1;
        end else begin
            n_value = i_ctrl.x;
            n_age   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_cell.value = r_value;
    assign o_cell.age   = r_age;
    assign o_cell.gt    = gt;
    assign o_cell.del   = occ && i_ctrl.full && (r_age == i_ctrl.size_m1);

endmodule

[hdl/smf_chain.sv]
// ----------------------------------------------------------------------------
// smf_chain
// Row of sorted cells with oldest-sample eviction and the two middle taps.
// ----------------------------------------------------------------------------
module smf_chain import smf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chain_ctrl i_ctrl,
    output t_sample     o_lo,
    output t_sample     o_hi
);

    t_cell_out        cells [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] del_vec;
    logic [IDX_W-1:0] del_idx;
    logic [CNT_W-1:0] lo_idx;
    logic [CNT_W-1:0] hi_idx;

    t_cell_out stub_left;
    t_cell_out stub_right;

    assign stub_left  = '{value: '0, age: '0, gt: 1'b0, del: 1'b0};
    assign stub_right = '{value: '0, age: '0, gt: 1'b1, del: 1'b0};

    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        t_cell_out left_nb;
        t_cell_out right_nb;
        if (k == 0) begin : g_first
            assign left_nb = stub_left;
        end else begin : g_mid_l
            assign left_nb = cells[k-1];
        end
        if (k == WINDOW_MAX - 1) begin : g_last
            assign right_nb = stub_right;
        end else begin : g_mid_r
            assign right_nb = cells[k+1];
        end
        smf_cell u_cell (
            .i_clk     (i_clk),
            .i_index   (IDX_W'(k)),
            .i_ctrl    (i_ctrl),
            .i_del_idx (del_idx),
            .i_left    (left_nb),
            .i_right   (right_nb),
            .o_cell    (cells[k])
        );
        assign del_vec[k] = cells[k].del;
    end

    always_comb begin
        del_idx = '0;
        for (int k = 0; k < WINDOW_MAX; k++) begin
            if (del_vec[k]) begin
                del_idx = del_idx | IDX_W'(k);
            end
        end
    end

    always_comb begin
        lo_idx = (i_ctrl.count - 1'b1) >> 1;
        hi_idx = i_ctrl.count >> 1;
        o_lo   = '0;
        o_hi   = '0;
        for (int k = 0; k < WINDOW_MAX; k++) begin
            if (lo_idx == CNT_W'(k)) begin
                o_lo = o_lo | cells[k].value;
            end
            if (hi_idx == CNT_W'(k)) begin
                o_hi = o_hi | cells[k].value;
            end
        end
    end

    a_del_onehot0 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(del_vec))
        else $error("more than one cell marked for eviction");

    a_del_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.ins && i_ctrl.full |-> $onehot(del_vec))
        else $error("full window insert without exactly one oldest cell");

    a_taps_ordered : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.count != '0 |-> $signed(o_lo) <= $signed(o_hi))
        else $error("middle taps out of order");

endmodule
